FILE: sv/gbtc_pkg.sv
// ----------------------------------------------------------------------------
// gbtc_pkg
// Shared types, constants and helpers of the ball track consolidator.
// ----------------------------------------------------------------------------
package gbtc_pkg;

    localparam int NumSlots  = 8;
    localparam int SlotW     = 3;
    localparam int FracBits  = 4;
    localparam int PosW      = 19;
    localparam int MmW       = 15;
    localparam int GateW     = 28;
    localparam int CntW      = 4;
    localparam int CmdW      = 1;
    localparam int InDataW   = 56;
    localparam int OutDataW  = 80;
    localparam int AddrW     = 5;

    localparam logic [AddrW-1:0] RegGate    = 5'd0;
    localparam logic [AddrW-1:0] RegConf    = 5'd4;
    localparam logic [AddrW-1:0] RegAreaMin = 5'd8;
    localparam logic [AddrW-1:0] RegAreaMax = 5'd12;
    localparam logic [AddrW-1:0] RegVanish  = 5'd16;
    localparam logic [AddrW-1:0] RegPromote = 5'd20;

    localparam logic CmdDetect = 1'b0;
    localparam logic CmdFrame  = 1'b1;

    typedef enum logic [3:0] {
        t_ST_IDLE,
        t_ST_DET,
        t_ST_DET_WAIT,
        t_ST_EOF_SLOT,
        t_ST_EOF_DIV,
        t_ST_EOF_WR,
        t_ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        t_OP_NONE,
        t_OP_SEED,
        t_OP_MATCH,
        t_OP_REFRESH,
        t_OP_PREDICT,
        t_OP_DIV_START
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SlotW-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic             div_done;
        logic             det_ok;
        logic             matched;
        logic             valid;
        logic [CntW-1:0]  hits_after;
        logic [CntW-1:0]  misses;
    } t_stat;

    function automatic logic signed [PosW-1:0] sat19(input logic signed [PosW+2:0] v);
        logic signed [PosW+2:0] lo;
        logic signed [PosW+2:0] hi;
        lo = -(22'sd1 <<< (PosW-1));
        hi = (22'sd1 <<< (PosW-1)) - 22'sd1;
        if (v < lo) return lo[PosW-1:0];
        if (v > hi) return hi[PosW-1:0];
        return v[PosW-1:0];
    endfunction

    function automatic logic signed [PosW-1:0] to_fine(input logic signed [MmW-1:0] mm);
        return {mm, {FracBits{1'b0}}};
    endfunction

endpackage

FILE: sv/gbtc_ctrl.sv
// ----------------------------------------------------------------------------
// gbtc_ctrl
// Sequencer: walks slots for detections and frame ends, drives the datapath.
// ----------------------------------------------------------------------------
module gbtc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_cmd,
    input  logic                 i_out_free,
    input  gbtc_pkg::t_stat      i_stat,
    input  logic [3:0]           i_vanish,
    input  logic [3:0]           i_promote,
    output gbtc_pkg::t_cmd       o_cmd,
    output logic                 o_idle,
    output logic                 o_emit,
    output logic                 o_locked,
    output logic                 o_any_clear,
    output logic                 o_drop,
    output logic                 o_promote,
    output logic                 o_unlock,
    output logic                 o_seed_end
);
    import gbtc_pkg::*;

    t_state           r_state, n_state;
    logic [SlotW:0]   r_slot, n_slot;
    logic             r_locked, n_locked;
    logic             r_seeding, n_seeding;
    logic [SlotW-1:0] r_chosen, n_chosen;
    logic             r_any, n_any;
    logic             r_is_eof, n_is_eof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= t_ST_IDLE;
            r_slot    <= '0;
            r_locked  <= 1'b0;
            r_seeding <= 1'b1;
            r_chosen  <= '0;
            r_any     <= 1'b0;
            r_is_eof  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_slot    <= n_slot;
            r_locked  <= n_locked;
            r_seeding <= n_seeding;
            r_chosen  <= n_chosen;
            r_any     <= n_any;
            r_is_eof  <= n_is_eof;
        end
    end

    logic [SlotW-1:0] w_cur;
    assign w_cur = r_locked ? r_chosen : r_slot[SlotW-1:0];

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_locked    = r_locked;
        n_seeding   = r_seeding;
        n_chosen    = r_chosen;
        n_any       = r_any;
        n_is_eof    = r_is_eof;
        o_cmd.op    = t_OP_NONE;
        o_cmd.slot  = w_cur;
        o_idle      = 1'b0;
        o_emit      = 1'b0;
        o_any_clear = 1'b0;
        o_drop      = 1'b0;
        o_promote   = 1'b0;
        o_unlock    = 1'b0;
        o_seed_end  = 1'b0;
        case (r_state)
            t_ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_slot   = '0;
                    n_any    = 1'b0;
                    n_is_eof = (i_cmd == CmdFrame);
                    n_state  = (i_cmd == CmdFrame) ? t_ST_EOF_SLOT : t_ST_DET;
                end
            end
            t_ST_DET: begin
                // one slot per cycle; seeding takes first free slot
                if (!i_stat.det_ok) begin
                    n_state = t_ST_IDLE;
                end else if (r_locked) begin
                    if (i_stat.valid) o_cmd.op = t_OP_MATCH;
                    n_state = t_ST_IDLE;
                end else if (r_seeding) begin
                    if (!i_stat.valid) begin
                        o_cmd.op = t_OP_SEED;
                        n_state  = t_ST_IDLE;
                    end else if (r_slot == (SlotW+1)'(NumSlots-1)) begin
                        n_state = t_ST_IDLE;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end else begin
                    if (i_stat.valid) o_cmd.op = t_OP_MATCH;
                    if (r_slot == (SlotW+1)'(NumSlots-1)) n_state = t_ST_IDLE;
                    else n_slot = r_slot + 1'b1;
                end
            end
            t_ST_EOF_SLOT: begin
                if (r_locked) begin
                    if (!i_stat.valid) begin
                        o_unlock = 1'b1; n_locked = 1'b0; n_seeding = 1'b1;
                        n_state = t_ST_OUT;
                    end else if (i_stat.matched) begin
                        o_cmd.op = t_OP_DIV_START; n_state = t_ST_EOF_DIV;
                    end else if (i_stat.misses < i_vanish) begin
                        o_cmd.op = t_OP_PREDICT; n_state = t_ST_OUT;
                    end else begin
                        o_unlock = 1'b1; n_locked = 1'b0; n_seeding = 1'b1;
                        n_state = t_ST_OUT;
                    end
                end else if (r_seeding) begin
                    o_seed_end = 1'b1; n_seeding = 1'b0; n_state = t_ST_OUT;
                end else if (r_slot[SlotW]) begin
                    if (!r_any) n_seeding = 1'b1;
                    n_state = t_ST_OUT;
                end else if (!i_stat.valid) begin
                    n_slot = r_slot + 1'b1;
                end else if (i_stat.matched) begin
                    o_cmd.op = t_OP_DIV_START; n_state = t_ST_EOF_DIV;
                end else if (i_stat.misses < i_vanish) begin
                    o_cmd.op = t_OP_PREDICT; n_any = 1'b1; n_slot = r_slot + 1'b1;
                end else begin
                    o_drop = 1'b1; n_slot = r_slot + 1'b1;
                end
            end
            t_ST_EOF_DIV: begin
                if (i_stat.div_done) n_state = t_ST_EOF_WR;
            end
            t_ST_EOF_WR: begin
                o_cmd.op = t_OP_REFRESH;
                if (r_locked) begin
                    n_state = t_ST_OUT;
                end else if (i_stat.hits_after >= i_promote) begin
                    o_promote = 1'b1; n_locked = 1'b1;
                    n_chosen = r_slot[SlotW-1:0]; n_state = t_ST_OUT;
                end else begin
                    n_any = 1'b1; n_slot = r_slot + 1'b1; n_state = t_ST_EOF_SLOT;
                end
            end
            t_ST_OUT: begin
                if (i_out_free) begin
                    o_emit = 1'b1;
                    n_state = t_ST_IDLE;
                end
            end
            default: n_state = t_ST_IDLE;
        endcase
    end

    assign o_locked = r_locked;
    logic w_unused;
    assign w_unused = r_is_eof;
endmodule

FILE: sv/gbtc_div.sv
// ----------------------------------------------------------------------------
// gbtc_div
// Restoring divider: signed 21-bit dividends by 5-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module gbtc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [20:0]           i_num_x,
    input  logic signed [20:0]           i_num_y,
    input  logic [4:0]                   i_den,
    output logic                         o_done,
    output logic signed [20:0]           o_q_x,
    output logic signed [20:0]           o_q_y
);
    import gbtc_pkg::*;

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [20:0] r_ax, r_ay, r_qx, r_qy;
    logic [5:0]  r_rx, r_ry;
    logic [4:0]  r_den;
    logic        r_nx, r_ny;
    logic [5:0]  w_tx, w_ty;

    assign w_tx = {r_rx[4:0], r_ax[20]};
    assign w_ty = {r_ry[4:0], r_ay[20]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd21;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ax  <= i_num_x[20] ? 21'(-i_num_x) : i_num_x;
            r_ay  <= i_num_y[20] ? 21'(-i_num_y) : i_num_y;
            r_nx  <= i_num_x[20];
            r_ny  <= i_num_y[20];
            r_den <= i_den;
            r_rx  <= '0;
            r_ry  <= '0;
        end else if (r_busy) begin
            r_ax <= {r_ax[19:0], 1'b0};
            r_ay <= {r_ay[19:0], 1'b0};
            if (w_tx >= {1'b0, r_den}) begin
                r_rx <= w_tx - {1'b0, r_den}; r_qx <= {r_qx[19:0], 1'b1};
            end else begin
                r_rx <= w_tx; r_qx <= {r_qx[19:0], 1'b0};
            end
            if (w_ty >= {1'b0, r_den}) begin
                r_ry <= w_ty - {1'b0, r_den}; r_qy <= {r_qy[19:0], 1'b1};
            end else begin
                r_ry <= w_ty; r_qy <= {r_qy[19:0], 1'b0};
            end
        end
    end

    assign o_q_x = r_nx ? 21'(-r_qx) : r_qx;
    assign o_q_y = r_ny ? 21'(-r_qy) : r_qy;
endmodule

FILE: sv/gbtc_dp.sv
// ----------------------------------------------------------------------------
// gbtc_dp
// Slot table, gating, distance, velocity and prediction arithmetic.
// ----------------------------------------------------------------------------
module gbtc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [gbtc_pkg::InDataW-1:0]      i_data,
    input  gbtc_pkg::t_cmd                    i_cmd,
    input  logic                              i_drop,
    input  logic                              i_promote,
    input  logic                              i_unlock,
    input  logic                              i_locked,
    input  logic                              i_emit,
    input  logic [27:0]                       i_gate_r,
    input  logic [7:0]                        i_conf_min,
    input  logic [15:0]                       i_area_min,
    input  logic [15:0]                       i_area_max,
    output gbtc_pkg::t_stat                   o_stat,
    output logic [gbtc_pkg::OutDataW-1:0]     o_result,
    output logic                              o_res_locked
);
    import gbtc_pkg::*;

    logic [NumSlots-1:0]         r_valid, r_matched;
    logic signed [PosW-1:0]      r_last_x [NumSlots];
    logic signed [PosW-1:0]      r_last_y [NumSlots];
    logic signed [PosW-1:0]      r_pred_x [NumSlots];
    logic signed [PosW-1:0]      r_pred_y [NumSlots];
    logic signed [PosW-1:0]      r_vel_x  [NumSlots];
    logic signed [PosW-1:0]      r_vel_y  [NumSlots];
    logic signed [MmW-1:0]       r_mx     [NumSlots];
    logic signed [MmW-1:0]       r_my     [NumSlots];
    logic [GateW-1:0]            r_gate   [NumSlots];
    logic [CntW-1:0]             r_hits   [NumSlots];
    logic [CntW-1:0]             r_miss   [NumSlots];

    logic signed [MmW-1:0]       r_bx, r_by;
    logic                        r_ok;

    logic [SlotW-1:0]            s;
    assign s = i_cmd.slot;

    // distance: |d| up to 2^20, sum of squares 42 bits
    logic signed [20:0]          w_dx, w_dy;
    logic [20:0]                 w_ax, w_ay;
    logic [41:0]                 w_d2;
    logic [33:0]                 w_dsh;
    logic [GateW-1:0]            w_dist;
    assign w_dx  = 21'(to_fine(r_bx)) - 21'(r_pred_x[s]);
    assign w_dy  = 21'(to_fine(r_by)) - 21'(r_pred_y[s]);
    assign w_ax  = w_dx[20] ? 21'(-w_dx) : w_dx;
    assign w_ay  = w_dy[20] ? 21'(-w_dy) : w_dy;
    assign w_d2  = 42'(w_ax * w_ax) + 42'(w_ay * w_ay);
    assign w_dsh = 34'(w_d2 >> (2*FracBits));
    assign w_dist = (w_dsh > 34'(28'hFFFFFFF)) ? 28'hFFFFFFF : w_dsh[GateW-1:0];

    logic                        w_div_done;
    logic signed [20:0]          w_qx, w_qy;
    gbtc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == t_OP_DIV_START),
        .i_num_x (21'(to_fine(r_mx[s])) - 21'(r_last_x[s])),
        .i_num_y (21'(to_fine(r_my[s])) - 21'(r_last_y[s])),
        .i_den   (5'(r_miss[s]) + 5'd1),
        .o_done  (w_div_done),
        .o_q_x   (w_qx),
        .o_q_y   (w_qy)
    );

    logic [CntW-1:0] w_hits_inc;
    assign w_hits_inc = (r_hits[s] == 4'hF) ? 4'hF : r_hits[s] + 4'd1;

    assign o_stat.div_done   = w_div_done;
    assign o_stat.det_ok     = r_ok;
    assign o_stat.matched    = r_matched[s];
    assign o_stat.valid      = r_valid[s];
    assign o_stat.hits_after = w_hits_inc;
    assign o_stat.misses     = r_miss[s];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bx <= i_data[14:0];
            r_by <= i_data[29:15];
            r_ok <= (i_data[37:30] >= i_conf_min) && (i_data[53:38] >= i_area_min)
                    && (i_data[53:38] <= i_area_max);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_matched <= '0;
        end else begin
            case (i_cmd.op)
                t_OP_SEED: begin
                    r_valid[s]   <= 1'b1;
                    r_matched[s] <= 1'b0;
                end
                t_OP_MATCH: begin
                    if (w_dist <= r_gate[s]) r_matched[s] <= 1'b1;
                end
                t_OP_REFRESH, t_OP_PREDICT: r_matched[s] <= 1'b0;
                default: ;
            endcase
            if (i_drop) r_valid[s] <= 1'b0;
            if (i_promote) begin
                r_matched <= '0;
                r_valid   <= NumSlots'(1) << s;
            end
            if (i_unlock) begin
                r_valid   <= '0;
                r_matched <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            t_OP_SEED: begin
                r_last_x[s] <= to_fine(r_bx); r_pred_x[s] <= to_fine(r_bx);
                r_last_y[s] <= to_fine(r_by); r_pred_y[s] <= to_fine(r_by);
                r_vel_x[s]  <= '0; r_vel_y[s] <= '0;
                r_mx[s] <= r_bx; r_my[s] <= r_by;
                r_gate[s] <= i_gate_r;
                r_hits[s] <= '0; r_miss[s] <= '0;
            end
            t_OP_MATCH: begin
                if (w_dist <= r_gate[s]) begin
                    r_mx[s] <= r_bx; r_my[s] <= r_by; r_gate[s] <= w_dist;
                end
            end
            t_OP_REFRESH: begin
                r_vel_x[s]  <= sat19(22'(w_qx));
                r_vel_y[s]  <= sat19(22'(w_qy));
                r_last_x[s] <= to_fine(r_mx[s]); r_pred_x[s] <= to_fine(r_mx[s]);
                r_last_y[s] <= to_fine(r_my[s]); r_pred_y[s] <= to_fine(r_my[s]);
                r_gate[s] <= i_gate_r;
                r_hits[s] <= w_hits_inc;
                r_miss[s] <= '0;
            end
            t_OP_PREDICT: begin
                r_pred_x[s] <= sat19(22'(r_pred_x[s]) + 22'(r_vel_x[s]));
                r_pred_y[s] <= sat19(22'(r_pred_y[s]) + 22'(r_vel_y[s]));
                r_miss[s] <= (r_miss[s] == 4'hF) ? 4'hF : r_miss[s] + 4'd1;
                r_hits[s] <= '0;
            end
            default: ;
        endcase
    end

    logic [CntW-1:0] w_cnt;
    always_comb begin
        w_cnt = '0;
        for (int k = 0; k < NumSlots; k++) w_cnt = w_cnt + CntW'(r_valid[k]);
    end

    always_ff @(posedge i_clk) begin
        if (i_emit) begin
            if (i_locked && r_valid[s]) begin
                o_result     <= {4'b0, r_vel_y[s], r_vel_x[s], r_pred_y[s], r_pred_x[s]};
                o_res_locked <= 1'b1;
            end else begin
                o_result     <= {w_cnt, 76'b0};
                o_res_locked <= 1'b0;
            end
        end
    end
endmodule

FILE: sv/gated_ball_track_consolidator.sv
// ----------------------------------------------------------------------------
// gated_ball_track_consolidator
// Gated nearest-neighbor ball tracker with constant-velocity prediction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries requests: detections (tuser 0) and frame ends
//   (tuser 1). A detection yields no result; a frame end yields one result
//   on the master stream with the lock flag on tuser and predicted position,
//   velocity and candidate count on tdata.
//   A detection checks only the chosen slot while locked and otherwise walks
//   the slots of the eight-entry table one per cycle. While not seeding, a
//   frame end walks the slots one per cycle (only the chosen slot while
//   locked), pausing while the serial divider works out the velocity of
//   each matched slot.
//   One request is in flight at a time; s_tready is high only when idle.
//   The result sits in an output register; the next request is accepted
//   while it waits, and the block stalls before writing a new result over
//   it until the receiver takes it.
//   Reset empties the table, unlocks and restarts seeding; registers return
//   to their defaults.
// ----------------------------------------------------------------------------
module gated_ball_track_consolidator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: ball_x, ball_y, confidence, blob_area
    input  logic [gbtc_pkg::InDataW-1:0]      s_tdata,
    // tuser: command
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: track_x, track_y, track_vx, track_vy, candidate_count
    output logic [gbtc_pkg::OutDataW-1:0]     m_tdata,
    // tuser: locked
    output logic [0:0]                        m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gbtc_pkg::AddrW-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import gbtc_pkg::*;

    logic [27:0] r_gate_r;
    logic [7:0]  r_conf_min;
    logic [15:0] r_area_min, r_area_max;
    logic [3:0]  r_vanish, r_promote;
    logic        r_out_valid;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_r   <= 28'd10000;
            r_conf_min <= '0;
            r_area_min <= '0;
            r_area_max <= 16'hFFFF;
            r_vanish   <= 4'd5;
            r_promote  <= 4'd5;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                RegGate:    r_gate_r   <= pwdata[27:0];
                RegConf:    r_conf_min <= pwdata[7:0];
                RegAreaMin: r_area_min <= pwdata[15:0];
                RegAreaMax: r_area_max <= pwdata[15:0];
                RegVanish:  r_vanish   <= pwdata[3:0];
                RegPromote: r_promote  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            RegGate:    prdata = {4'b0, r_gate_r};
            RegConf:    prdata = {24'b0, r_conf_min};
            RegAreaMin: prdata = {16'b0, r_area_min};
            RegAreaMax: prdata = {16'b0, r_area_max};
            RegVanish:  prdata = {28'b0, r_vanish};
            RegPromote: prdata = {28'b0, r_promote};
            default:    prdata = '0;
        endcase
    end

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_idle, w_emit, w_locked, w_any, w_drop, w_prom, w_unlock, w_seed_end;
    logic  w_start;

    assign s_tready = w_idle;
    assign w_start  = s_tvalid && w_idle;

    gbtc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_cmd       (s_tuser[0]),
        .i_out_free  (!r_out_valid || m_tready),
        .i_stat      (w_stat),
        .i_vanish    (r_vanish),
        .i_promote   (r_promote),
        .o_cmd       (w_cmd),
        .o_idle      (w_idle),
        .o_emit      (w_emit),
        .o_locked    (w_locked),
        .o_any_clear (w_any),
        .o_drop      (w_drop),
        .o_promote   (w_prom),
        .o_unlock    (w_unlock),
        .o_seed_end  (w_seed_end)
    );

    gbtc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_start),
        .i_data       (s_tdata),
        .i_cmd        (w_cmd),
        .i_drop       (w_drop),
        .i_promote    (w_prom),
        .i_unlock     (w_unlock),
        .i_locked     (w_locked),
        .i_emit       (w_emit),
        .i_gate_r     (r_gate_r),
        .i_conf_min   (r_conf_min),
        .i_area_min   (r_area_min),
        .i_area_max   (r_area_max),
        .o_stat       (w_stat),
        .o_result     (m_tdata),
        .o_res_locked (m_tuser)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (w_emit) r_out_valid <= 1'b1;
        else if (m_tready) r_out_valid <= 1'b0;
    end

    assign m_tvalid = r_out_valid;

    logic w_unused;
    assign w_unused = w_any ^ w_seed_end;
endmodule

FILE: sv/gbtc_checker.sv
// ----------------------------------------------------------------------------
// gbtc_checker
// Port-level checks of the ball track consolidator.
// ----------------------------------------------------------------------------
module gbtc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [0:0]  m_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped while stalled");
    a_unlocked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[75:0] == '0)
        else $error("unlocked result carries track data");
    a_locked_nocnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[79:76] == '0)
        else $error("locked result carries candidate count");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[79:76] <= 4'd8)
        else $error("candidate count too large");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");
endmodule

bind gated_ball_track_consolidator gbtc_checker u_gbtc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: bench/gated_ball_track_consolidator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_ball_track_consolidator_checker
// Watches the request, result and register channels of the ball track
// consolidator. It keeps its own copy of the tracker state and registers,
// predicts the frame report of every accepted frame end and compares each
// report on the result stream, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module gated_ball_track_consolidator_checker
    import gbtc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [InDataW-1:0]   s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OutDataW-1:0]  m_tdata,
    input  logic [0:0]           m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [AddrW-1:0]     paddr,
    input  logic [31:0]          pwdata,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int  PosLo   = -262144;
    localparam int  PosHi   = 262143;
    localparam longint GateTop = 268435455;

    typedef struct {
        bit             locked;
        bit [PosW-1:0]  tx;
        bit [PosW-1:0]  ty;
        bit [PosW-1:0]  vx;
        bit [PosW-1:0]  vy;
        bit [CntW-1:0]  cnt;
    } report_t;

    report_t frame_reports[$];

    bit [GateW-1:0] r_gate;
    bit [7:0]       r_conf;
    bit [15:0]      r_amin;
    bit [15:0]      r_amax;
    bit [3:0]       r_vanish;
    bit [3:0]       r_promote;

    bit  trk_locked;
    bit  trk_seeding;
    int  trk_chosen;
    bit  sl_valid   [NumSlots];
    bit  sl_matched [NumSlots];
    int  sl_last_x  [NumSlots];
    int  sl_last_y  [NumSlots];
    int  sl_pred_x  [NumSlots];
    int  sl_pred_y  [NumSlots];
    int  sl_vel_x   [NumSlots];
    int  sl_vel_y   [NumSlots];
    int  sl_mx      [NumSlots];
    int  sl_my      [NumSlots];
    longint sl_gate [NumSlots];
    int  sl_hits    [NumSlots];
    int  sl_misses  [NumSlots];

    function automatic int clamp_pos(longint v);
        if (v < PosLo) return PosLo;
        if (v > PosHi) return PosHi;
        return int'(v);
    endfunction

    function automatic int mm_to_fine(int mm);
        return clamp_pos(longint'(mm) * (1 << FracBits));
    endfunction

    function automatic longint gate_distance(int bx, int by, int px, int py);
        longint dx;
        longint dy;
        longint d;
        dx = longint'(bx) * (1 << FracBits) - px;
        dy = longint'(by) * (1 << FracBits) - py;
        d = (dx * dx + dy * dy) >>> (2 * FracBits);
        return (d > GateTop) ? GateTop : d;
    endfunction

    function automatic void try_gate(int s, int bx, int by);
        longint d;
        d = gate_distance(bx, by, sl_pred_x[s], sl_pred_y[s]);
        if (d <= sl_gate[s]) begin
            sl_mx[s] = bx;
            sl_my[s] = by;
            sl_gate[s] = d;
            sl_matched[s] = 1;
        end
    endfunction

    function automatic void seed(int s, int bx, int by);
        sl_valid[s] = 1;
        sl_matched[s] = 0;
        sl_last_x[s] = mm_to_fine(bx);
        sl_pred_x[s] = sl_last_x[s];
        sl_last_y[s] = mm_to_fine(by);
        sl_pred_y[s] = sl_last_y[s];
        sl_vel_x[s] = 0;
        sl_vel_y[s] = 0;
        sl_mx[s] = bx;
        sl_my[s] = by;
        sl_gate[s] = r_gate;
        sl_hits[s] = 0;
        sl_misses[s] = 0;
    endfunction

    function automatic void refresh(int s);
        longint dv;
        int fx;
        int fy;
        dv = sl_misses[s] + 1;
        fx = mm_to_fine(sl_mx[s]);
        fy = mm_to_fine(sl_my[s]);
        sl_vel_x[s] = clamp_pos((longint'(fx) - sl_last_x[s]) / dv);
        sl_vel_y[s] = clamp_pos((longint'(fy) - sl_last_y[s]) / dv);
        sl_last_x[s] = fx;
        sl_pred_x[s] = fx;
        sl_last_y[s] = fy;
        sl_pred_y[s] = fy;
        sl_gate[s] = r_gate;
        if (sl_hits[s] < 15) sl_hits[s]++;
        sl_misses[s] = 0;
    endfunction

    function automatic void coast(int s);
        sl_pred_x[s] = clamp_pos(longint'(sl_pred_x[s]) + sl_vel_x[s]);
        sl_pred_y[s] = clamp_pos(longint'(sl_pred_y[s]) + sl_vel_y[s]);
        if (sl_misses[s] < 15) sl_misses[s]++;
        sl_hits[s] = 0;
    endfunction

    function automatic void drop_all();
        for (int s = 0; s < NumSlots; s++) begin
            sl_valid[s] = 0;
            sl_matched[s] = 0;
        end
    endfunction

    function automatic void close_frame();
        bit any;
        int s;
        any = 0;
        if (trk_locked) begin
            s = trk_chosen;
            if (!sl_valid[s]) begin
                trk_locked = 0;
                trk_seeding = 1;
                drop_all();
                return;
            end
            if (sl_matched[s]) begin
                refresh(s);
            end else if (sl_misses[s] < r_vanish) begin
                coast(s);
            end else begin
                trk_locked = 0;
                trk_seeding = 1;
                drop_all();
            end
            sl_matched[s] = 0;
            return;
        end
        if (trk_seeding) begin
            trk_seeding = 0;
            return;
        end
        for (s = 0; s < NumSlots; s++) begin
            if (!sl_valid[s]) continue;
            if (sl_matched[s]) begin
                sl_matched[s] = 0;
                refresh(s);
                if (sl_hits[s] >= r_promote) begin
                    for (int k = 0; k < NumSlots; k++) begin
                        sl_matched[k] = 0;
                        if (k != s) sl_valid[k] = 0;
                    end
                    trk_chosen = s;
                    trk_locked = 1;
                    return;
                end
            end else if (sl_misses[s] < r_vanish) begin
                coast(s);
            end else begin
                sl_valid[s] = 0;
            end
            if (sl_valid[s]) any = 1;
        end
        if (!any) trk_seeding = 1;
    endfunction

    function automatic void take_request(logic cmd, logic [InDataW-1:0] d);
        logic signed [MmW-1:0] bx;
        logic signed [MmW-1:0] by;
        bit [7:0]  conf;
        bit [15:0] area;
        report_t   rep;
        int        n;
        bx = d[14:0];
        by = d[29:15];
        conf = d[37:30];
        area = d[53:38];
        if (cmd == CmdDetect) begin
            if (conf < r_conf || area < r_amin || area > r_amax) return;
            if (trk_locked) begin
                if (sl_valid[trk_chosen]) try_gate(trk_chosen, bx, by);
            end else if (trk_seeding) begin
                for (int s = 0; s < NumSlots; s++) begin
                    if (!sl_valid[s]) begin
                        seed(s, bx, by);
                        break;
                    end
                end
            end else begin
                for (int s = 0; s < NumSlots; s++)
                    if (sl_valid[s]) try_gate(s, bx, by);
            end
            return;
        end
        close_frame();
        rep = '{default: 0};
        rep.locked = trk_locked;
        if (trk_locked) begin
            rep.tx = sl_pred_x[trk_chosen];
            rep.ty = sl_pred_y[trk_chosen];
            rep.vx = sl_vel_x[trk_chosen];
            rep.vy = sl_vel_y[trk_chosen];
        end else begin
            n = 0;
            for (int s = 0; s < NumSlots; s++) if (sl_valid[s]) n++;
            rep.cnt = n;
        end
        frame_reports.insert(frame_reports.size(), rep);
    endfunction

    assign o_pending = frame_reports.size();

    always @(posedge i_clk) begin
        report_t want;
        bit [PosW-1:0] gx;
        bit [PosW-1:0] gy;
        bit [PosW-1:0] gvx;
        bit [PosW-1:0] gvy;
        bit [CntW-1:0] gc;
        if (!i_rst_n) begin
            r_gate = 10000;
            r_conf = 0;
            r_amin = 0;
            r_amax = 16'hFFFF;
            r_vanish = 5;
            r_promote = 5;
            trk_locked = 0;
            trk_seeding = 1;
            trk_chosen = 0;
            drop_all();
            frame_reports.delete();
            o_fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                gx = m_tdata[18:0];
                gy = m_tdata[37:19];
                gvx = m_tdata[56:38];
                gvy = m_tdata[75:57];
                gc = m_tdata[79:76];
                if (frame_reports.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: frame report with none pending: %h %h",
                            $realtime, m_tuser, m_tdata);
                end else begin
                    want = frame_reports.pop_front();
                    if (want.locked != m_tuser[0] || want.tx != gx || want.ty != gy
                        || want.vx != gvx || want.vy != gvy || want.cnt != gc) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"%0t: report mismatch exp lk=%0d x=%h y=%h vx=%h",
                                " vy=%h n=%0d got lk=%0d x=%h y=%h vx=%h vy=%h n=%0d"},
                                $realtime, want.locked, want.tx, want.ty, want.vx,
                                want.vy, want.cnt, m_tuser[0], gx, gy, gvx, gvy, gc);
                    end
                end
            end
            if (s_tvalid && s_tready) take_request(s_tuser[0], s_tdata);
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    RegGate:    r_gate = pwdata[GateW-1:0];
                    RegConf:    r_conf = pwdata[7:0];
                    RegAreaMin: r_amin = pwdata[15:0];
                    RegAreaMax: r_amax = pwdata[15:0];
                    RegVanish:  r_vanish = pwdata[3:0];
                    RegPromote: r_promote = pwdata[3:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: bench/gated_ball_track_consolidator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_ball_track_consolidator_test
// Drives the ball track consolidator with directed extremes and then with
// frames of a moving ball plus clutter under several register settings,
// with random gaps and stalls on both streams. A checker module predicts
// and compares the frame reports; this top gives the verdict.
// ----------------------------------------------------------------------------
module gated_ball_track_consolidator_test;
    import gbtc_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OutDataW-1:0]  m_tdata;
    logic [0:0]           m_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AddrW-1:0]     paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending;
    int                   cycles;
    int                   stall_left;

    bit [7:0]  cur_conf;
    bit [15:0] cur_amin;
    bit [15:0] cur_amax;
    int        ball_x;
    int        ball_y;
    int        ball_vx;
    int        ball_vy;

    gated_ball_track_consolidator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    gated_ball_track_consolidator_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 3000000) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready <= 0;
            stall_left <= stall_left - 1;
        end else if (m_tready && $urandom_range(0, 3) == 0) begin
            m_tready <= 0;
            stall_left <= pick_gap();
        end else begin
            m_tready <= 1;
        end
    end

    task automatic send_request(bit cmd, int x, int y, int conf, int area);
        int gap;
        logic [MmW-1:0] qx;
        logic [MmW-1:0] qy;
        gap = ($urandom_range(0, 9) < 3) ? 0 : pick_gap();
        qx = x;
        qy = y;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {2'b0, 16'(area), 8'(conf), qy, qx};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic detect(int x, int y);
        send_request(CmdDetect, x, y, $urandom_range(cur_conf, 255),
            (cur_amin <= cur_amax) ? $urandom_range(cur_amin, cur_amax) : $urandom_range(0, 65535));
    endtask

    task automatic end_frame();
        send_request(CmdFrame, $urandom_range(0, 32767), $urandom_range(0, 32767),
            $urandom_range(0, 255), $urandom_range(0, 65535));
    endtask

    task automatic reg_write(logic [AddrW-1:0] addr, int width, int value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= value | ($urandom << width);
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic program_regs(int gate, int conf, int amin, int amax, int van, int prom);
        reg_write(RegGate, GateW, gate);
        reg_write(RegConf, 8, conf);
        reg_write(RegAreaMin, 16, amin);
        reg_write(RegAreaMax, 16, amax);
        reg_write(RegVanish, 4, van);
        reg_write(RegPromote, 4, prom);
        cur_conf = conf;
        cur_amin = amin;
        cur_amax = amax;
    endtask

    task automatic run_frames(int n_items);
        int sent;
        int k;
        sent = 0;
        ball_x = $urandom_range(0, 20000) - 10000;
        ball_y = $urandom_range(0, 20000) - 10000;
        ball_vx = $urandom_range(0, 200) - 100;
        ball_vy = $urandom_range(0, 200) - 100;
        while (sent < n_items) begin
            ball_x += ball_vx;
            ball_y += ball_vy;
            if (ball_x > 15000 || ball_x < -15000) ball_vx = -ball_vx;
            if (ball_y > 15000 || ball_y < -15000) ball_vy = -ball_vy;
            if ($urandom_range(0, 9) < 8) begin
                detect(ball_x + $urandom_range(0, 6) - 3, ball_y + $urandom_range(0, 6) - 3);
                sent++;
            end
            k = $urandom_range(0, 2);
            repeat (k) begin
                if ($urandom_range(0, 1))
                    send_request(CmdDetect, $urandom_range(0, 32767) - 16384,
                        $urandom_range(0, 32767) - 16384, $urandom_range(0, 255),
                        $urandom_range(0, 65535));
                else
                    detect(ball_x + $urandom_range(0, 400) - 200,
                        ball_y + $urandom_range(0, 400) - 200);
                sent++;
            end
            end_frame();
            sent++;
        end
    endtask

    initial begin
        i_rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        cur_conf = 0;
        cur_amin = 0;
        cur_amax = 16'hFFFF;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        end_frame();
        send_request(CmdDetect, -16384, -16384, 255, 65535);
        send_request(CmdDetect, 16383, 16383, 0, 0);
        send_request(CmdDetect, 0, 0, 128, 30000);
        for (int i = 0; i < 7; i++) send_request(CmdDetect, 100 * i, -100 * i, 200, 100);
        end_frame();
        send_request(CmdDetect, -16384, -16384, 255, 65535);
        send_request(CmdDetect, 16383, 16383, 255, 0);
        send_request(CmdDetect, 16300, 16300, 255, 0);
        end_frame();
        end_frame();
        end_frame();
        send_request(CmdDetect, -16384, 16383, 255, 10);
        end_frame();
        end_frame();
        drain();

        run_frames(150);
        drain();
        program_regs(200000, 100, 100, 60000, 3, 3);
        run_frames(150);
        drain();
        program_regs(268435455, 0, 0, 65535, 15, 15);
        run_frames(150);
        drain();
        program_regs(0, 0, 0, 65535, 0, 1);
        run_frames(120);
        drain();
        program_regs(5000, 0, 5000, 100, 2, 2);
        run_frames(80);
        drain();
        program_regs(30000, 255, 0, 65535, 2, 0);
        run_frames(150);
        drain();
        program_regs(40000, 20, 1000, 50000, 4, 2);
        run_frames(200);
        drain();
        program_regs(10000, 0, 0, 65535, 5, 5);
        run_frames(200);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: gated_ball_track_consolidator.f
sv/gbtc_pkg.sv
sv/gbtc_ctrl.sv
sv/gbtc_div.sv
sv/gbtc_dp.sv
sv/gated_ball_track_consolidator.sv
sv/gbtc_checker.sv
bench/gated_ball_track_consolidator_checker.sv
bench/gated_ball_track_consolidator_test.sv
